// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dvt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and constants of the distance-vector table update core.
// ----------------------------------------------------------------------------
`default_nettype none

package dvt_pkg;

    localparam int NODE_W = 6;
    localparam int DIST_W = 6;
    localparam int FUNC_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_LINK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADV  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    localparam logic [CNT_W-1:0]  CNT_RESET = 7'd64;
    localparam logic [DIST_W-1:0] DIST_ONE  = 6'd1;
    localparam logic [DIST_W-1:0] DIST_MAX  = 6'd63;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LINK,
        CMD_ADV,
        CMD_READ,
        CMD_REJECT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } cmd_t;

    // One table entry: known flag, hop distance, next hop.
    typedef struct packed {
        logic              known;
        logic [DIST_W-1:0] metric;
        logic [NODE_W-1:0] hop;
    } entry_t;

    // Queue side signals between queue and back end.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/dvt_front.sv =====
// ----------------------------------------------------------------------------
// dvt_front
// Node-count register, request intake and classification into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dvt_front #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [dvt_pkg::CNT_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic [dvt_pkg::FUNC_W-1:0]  func,
    input  wire logic [dvt_pkg::NODE_W-1:0]  node_a,
    input  wire logic [dvt_pkg::NODE_W-1:0]  node_b,
    input  wire logic                        q_full,
    input  wire logic                        clr_busy,
    output      logic                        q_push,
    output      dvt_pkg::cmd_t               q_cmd,
    output      logic [$clog2(MAX_NODES+1)-1:0] n_eff
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [31:0] MAX_N32 = 32'(MAX_NODES);

    logic [dvt_pkg::CNT_W-1:0] node_count_reg;
    logic [31:0]               cnt32;
    logic [31:0]               n32;
    logic                      in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= dvt_pkg::CNT_RESET;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // clamp to 1..MAX_NODES
    always_comb
    begin
        cnt32 = 32'(node_count_reg);
        priority if (cnt32 == 32'd0)
        begin
            n32 = 32'd1;
        end
        else if (cnt32 > MAX_N32)
        begin
            n32 = MAX_N32;
        end
        else
        begin
            n32 = cnt32;
        end
    end

    assign n_eff    = CW'(n32);
    assign in_range = (32'(node_a) < n32) && (32'(node_b) < n32);

    always_comb
    begin
        q_cmd.node_a = node_a;
        q_cmd.node_b = node_b;
        q_cmd.op     = dvt_pkg::CMD_REJECT;
        if (in_range)
        begin
            unique case (func)
                dvt_pkg::FUNC_LINK:
                begin
                    if (node_a != node_b)
                    begin
                        q_cmd.op = dvt_pkg::CMD_LINK;
                    end
                end
                dvt_pkg::FUNC_ADV:
                begin
                    if (node_a != node_b)
                    begin
                        q_cmd.op = dvt_pkg::CMD_ADV;
                    end
                end
                dvt_pkg::FUNC_READ:
                begin
                    q_cmd.op = dvt_pkg::CMD_READ;
                end
                default:
                begin
                    q_cmd.op = dvt_pkg::CMD_REJECT;
                end
            endcase
        end
    end

    // no intake while the table is being cleared
    assign in_stall = q_full || clr_busy;
    assign q_push   = in_valid && !in_stall;

endmodule

`default_nettype wire

// ===== rtl/core/dvt_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dvt_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dvt_cmd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dvt_pkg::cmd_t     push_cmd,
    output      logic              full,
    input  wire logic              pop,
    output      dvt_pkg::q_head_t  head
);

    localparam int PW = dvt_pkg::CMDQ_PW;
    localparam int QW = dvt_pkg::CMDQ_CW;

    dvt_pkg::cmd_t entries_reg [dvt_pkg::CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [QW-1:0] count_reg;
    logic [QW-1:0] count_next;

    assign full       = (count_reg == QW'(dvt_pkg::CMDQ_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(dvt_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(dvt_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMPL(a_no_overflow, clk, rst_n, push && full, pop, "push into full queue")
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, head.valid, "pop from empty queue")
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= QW'(dvt_pkg::CMDQ_DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ===== rtl/core/dvt_back.sv =====
// ----------------------------------------------------------------------------
// dvt_back
// Table memory, clearing pass, command sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dvt_back #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [$clog2(MAX_NODES+1)-1:0] n_eff,
    input  wire dvt_pkg::q_head_t               head,
    output      logic                           q_pop,
    output      logic                           clr_busy,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic                           status,
    output      logic                           route_known,
    output      logic [dvt_pkg::DIST_W-1:0]     hop_distance,
    output      logic [dvt_pkg::NODE_W-1:0]     next_hop
);

    localparam int IW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_NODES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_ADV,
        S_READ,
        S_DONE
    } state_t;

    dvt_pkg::entry_t mem [DEPTH];

    state_t          state_reg,      state_next;
    dvt_pkg::cmd_t   cmd_reg,        cmd_next;
    logic [CW-1:0]   d_reg,          d_next;
    logic            p_reg,          p_next;
    logic [IW-1:0]   pd_reg,         pd_next;
    logic [IW-1:0]   clr_row_reg,    clr_row_next;
    logic [IW-1:0]   clr_col_reg,    clr_col_next;
    logic            res_status_reg, res_status_next;
    dvt_pkg::entry_t res_reg,        res_next;
    logic            out_valid_reg,  out_valid_next;
    logic            out_status_reg, out_status_next;
    dvt_pkg::entry_t out_reg,        out_next;

    dvt_pkg::entry_t rd_a_data_reg;
    dvt_pkg::entry_t rd_b_data_reg;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    dvt_pkg::entry_t wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_a_addr;
    logic [AW-1:0]   rd_b_addr;
    logic            issue;

    assign issue = (d_reg < n_eff);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        d_next          = d_reg;
        p_next          = 1'b0;
        pd_next         = pd_reg;
        clr_row_next    = clr_row_reg;
        clr_col_next    = clr_col_reg;
        res_status_next = res_status_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_next        = out_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_a_addr       = '0;
        rd_b_addr       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en          = 1'b1;
                wr_addr        = {clr_row_reg, clr_col_reg};
                wr_data.known  = (clr_row_reg == clr_col_reg);
                wr_data.metric = '0;
                wr_data.hop    = (clr_row_reg == clr_col_reg) ? dvt_pkg::NODE_W'(clr_row_reg)
                                                              : '0;
                if (clr_col_reg == LAST_IDX)
                begin
                    clr_col_next = '0;
                    clr_row_next = clr_row_reg + 1'b1;
                    if (clr_row_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    q_pop           = 1'b1;
                    cmd_next        = head.cmd;
                    res_status_next = 1'b0;
                    res_next        = '0;
                    unique case (head.cmd.op)
                        dvt_pkg::CMD_LINK:
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = {IW'(head.cmd.node_a), IW'(head.cmd.node_b)};
                            wr_data.known  = 1'b1;
                            wr_data.metric = dvt_pkg::DIST_ONE;
                            wr_data.hop    = head.cmd.node_b;
                            state_next     = S_LINK;
                        end
                        dvt_pkg::CMD_ADV:
                        begin
                            d_next     = '0;
                            state_next = S_ADV;
                        end
                        dvt_pkg::CMD_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_a_addr  = {IW'(head.cmd.node_a), IW'(head.cmd.node_b)};
                            state_next = S_READ;
                        end
                        default:
                        begin
                            res_status_next = 1'b1;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_LINK:
            begin
                wr_en          = 1'b1;
                wr_addr        = {IW'(cmd_reg.node_b), IW'(cmd_reg.node_a)};
                wr_data.known  = 1'b1;
                wr_data.metric = dvt_pkg::DIST_ONE;
                wr_data.hop    = cmd_reg.node_a;
                state_next     = S_DONE;
            end
            S_ADV:
            begin
                // reads for column d overlap the write-back of column d-1
                if (issue)
                begin
                    rd_en     = 1'b1;
                    rd_a_addr = {IW'(cmd_reg.node_a), d_reg[IW-1:0]};
                    rd_b_addr = {IW'(cmd_reg.node_b), d_reg[IW-1:0]};
                    p_next    = 1'b1;
                    pd_next   = d_reg[IW-1:0];
                    d_next    = d_reg + 1'b1;
                end
                if (p_reg && !rd_b_data_reg.known && rd_a_data_reg.known)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = {IW'(cmd_reg.node_b), pd_reg};
                    wr_data.known  = 1'b1;
                    wr_data.metric = (rd_a_data_reg.metric == dvt_pkg::DIST_MAX)
                                     ? dvt_pkg::DIST_MAX
                                     : rd_a_data_reg.metric + dvt_pkg::DIST_ONE;
                    wr_data.hop    = cmd_reg.node_a;
                end
                if (!issue && !p_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                if (rd_a_data_reg.known)
                begin
                    res_next = rd_a_data_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_next        = res_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cmd_reg        <= '0;
            d_reg          <= '0;
            p_reg          <= 1'b0;
            pd_reg         <= '0;
            clr_row_reg    <= '0;
            clr_col_reg    <= '0;
            res_status_reg <= 1'b0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            d_reg          <= d_next;
            p_reg          <= p_next;
            pd_reg         <= pd_next;
            clr_row_reg    <= clr_row_next;
            clr_col_reg    <= clr_col_next;
            res_status_reg <= res_status_next;
            res_reg        <= res_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_reg        <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_data_reg <= mem[rd_a_addr];
            rd_b_data_reg <= mem[rd_b_addr];
        end
    end

    assign clr_busy     = (state_reg == S_CLEAR);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign route_known  = out_reg.known;
    assign hop_distance = out_reg.metric;
    assign next_hop     = out_reg.hop;

    `ASSERT_IMPL(a_pop_has_cmd, clk, rst_n, q_pop, head.valid && state_reg == S_IDLE, "pop without a queued command")
    `ASSERT_IMPL(a_adv_row, clk, rst_n, state_reg == S_ADV && wr_en, wr_addr[AW-1:IW] == IW'(cmd_reg.node_b), "advertise wrote outside receiving row")
    `ASSERT_NEXT(a_done_load, clk, rst_n, state_reg == S_DONE && (!out_valid_reg || !out_stall), out_valid_reg && state_reg == S_IDLE, "result not loaded on finish")

endmodule

`default_nettype wire

// ===== rtl/core/distance_vector_table_update_core.sv =====
// ----------------------------------------------------------------------------
// distance_vector_table_update_core
// Per-node routing table with link, advertise and read requests.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  cfg     | cfg_we             | cfg_wdata (node_count)
//  in      | in_valid/in_stall  | func, node_a, node_b
//  out     | out_valid/out_stall| status, route_known, hop_distance, next_hop
//
//  An advertise walks the table memory one destination column per cycle, over
//  the active node count.
//  After reset a clearing pass writes MAX_NODES * MAX_NODES entries, one per
//  cycle (4096 at the default); in_stall is high throughout.
//  A two-entry request queue keeps intake going while the back end works or
//  while out_stall holds a finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_vector_table_update_core #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [dvt_pkg::CNT_W-1:0]   cfg_wdata,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic [dvt_pkg::FUNC_W-1:0]  func,
    input  wire logic [dvt_pkg::NODE_W-1:0]  node_a,
    input  wire logic [dvt_pkg::NODE_W-1:0]  node_b,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic                        status,
    output      logic                        route_known,
    output      logic [dvt_pkg::DIST_W-1:0]  hop_distance,
    output      logic [dvt_pkg::NODE_W-1:0]  next_hop
);

    localparam int CW = $clog2(MAX_NODES + 1);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             clr_busy;
    logic [CW-1:0]    n_eff;
    dvt_pkg::cmd_t    q_cmd;
    dvt_pkg::q_head_t q_head;

    dvt_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .node_a    (node_a),
        .node_b    (node_b),
        .q_full    (q_full),
        .clr_busy  (clr_busy),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .n_eff     (n_eff)
    );

    dvt_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    dvt_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_eff        (n_eff),
        .head         (q_head),
        .q_pop        (q_pop),
        .clr_busy     (clr_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .route_known  (route_known),
        .hop_distance (hop_distance),
        .next_hop     (next_hop)
    );

endmodule

`default_nettype wire
